[sv/kar_pkg.sv]
package kar_pkg;

   // key pad layout
   localparam int KEY_BITS    = 6;
   localparam int TIMER_BITS  = 16;
   localparam int REPEAT_KEYS = 4;
   localparam int CSR_BITS    = 16;

   // repeat keys are the low bits, the rest of the pad reports edges only
   localparam int NREP = (REPEAT_KEYS < KEY_BITS) ? REPEAT_KEYS : KEY_BITS;
   localparam logic [KEY_BITS-1:0] REP_MASK  = KEY_BITS'((1 << NREP) - 1);
   localparam logic [KEY_BITS-1:0] EDGE_MASK = ~REP_MASK;

   // reset values of the delay registers
   localparam logic [CSR_BITS-1:0] REPEAT_DELAY_RESET = CSR_BITS'(100);
   localparam logic [CSR_BITS-1:0] FIRST_PAUSE_RESET  = CSR_BITS'(500);

   // register indexes
   typedef enum logic [0:0] {
      CSR_REPEAT_DELAY = 1'b0,
      CSR_FIRST_PAUSE  = 1'b1
   } csr_index_type;

   typedef logic [TIMER_BITS-1:0] timer_type;
   typedef logic [KEY_BITS-1:0]   keys_type;

endpackage

[sv/keypad_auto_repeat.sv]
// Typematic auto-repeat for a six-key pad. Each req beat is one time tick carrying the
// sampled keys (bit0 up, bit1 down, bit2 left, bit3 right, bit4 A, bit5 B) and yields
// exactly one rsp beat with the held keys and a changed flag. A direction press reports
// a change and arms its timer with first_pause; while held, the key repeats a change
// every repeat_delay ticks after that; a release reports nothing. Any edge of A or B
// reports a change. One tick is taken every clock cycle unless a result is stalled; a
// tick passes an input register and then the result register, and the input register
// keeps taking one more tick while a result waits. Write repeat_delay (index 0) and
// first_pause (index 1) only while idle.
module keypad_auto_repeat (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [kar_pkg::KEY_BITS-1:0]   req_keys_now,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_changed,
   output logic [kar_pkg::KEY_BITS-1:0]   rsp_keys_held,
   input  logic                           csr_wr_en,
   input  kar_pkg::csr_index_type         csr_index,
   input  logic [kar_pkg::CSR_BITS-1:0]   csr_data
);

   logic [kar_pkg::CSR_BITS-1:0] repeat_delay_ff;
   logic [kar_pkg::CSR_BITS-1:0] first_pause_ff;

   logic                 tick_valid_ff;
   logic                 tick_valid_in;
   kar_pkg::keys_type    tick_keys_ff;

   kar_pkg::keys_type    held_ff;
   kar_pkg::keys_type    held_in;
   kar_pkg::timer_type   count_ff [kar_pkg::NREP];
   kar_pkg::timer_type   count_in [kar_pkg::NREP];

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_changed_ff;
   logic                 changed_in;
   kar_pkg::keys_type    rsp_keys_ff;

   logic                 advance;
   logic [31:0]          delay_ext;
   logic [31:0]          pause_ext;
   kar_pkg::timer_type   delay_load;
   kar_pkg::timer_type   pause_load;

   // handshake: tick stage moves when the result register is free or drains
   assign advance       = !rsp_valid_ff || rsp_ready;
   assign req_ready     = !tick_valid_ff || advance;
   assign tick_valid_in = req_valid && req_ready ? 1'b1 :
                          (advance ? 1'b0 : tick_valid_ff);
   assign rsp_valid_in  = advance ? tick_valid_ff : rsp_valid_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_changed   = rsp_changed_ff;
   assign rsp_keys_held = rsp_keys_ff;

   // reload values fitted to the timer width
   assign delay_ext  = 32'(repeat_delay_ff);
   assign pause_ext  = 32'(first_pause_ff);
   assign delay_load = delay_ext[kar_pkg::TIMER_BITS-1:0];
   assign pause_load = pause_ext[kar_pkg::TIMER_BITS-1:0];

   // per-key press, release and timer update
   always_comb begin
      changed_in = 1'b0;
      for (int i = 0; i < kar_pkg::NREP; i++) begin
         count_in[i] = count_ff[i];
         if (tick_keys_ff[i] && !held_ff[i]) begin
            count_in[i] = pause_load;
            changed_in  = 1'b1;
         end else if (!tick_keys_ff[i] && held_ff[i]) begin
            count_in[i] = '0;
         end else if (held_ff[i]) begin
            // running timer: fire at one or zero, else count down
            if (count_ff[i][kar_pkg::TIMER_BITS-1:1] == '0) begin
               count_in[i] = delay_load;
               changed_in  = 1'b1;
            end else begin
               count_in[i] = count_ff[i] - kar_pkg::TIMER_BITS'(1);
            end
         end
      end
      // edge keys report any change
      if (((held_ff ^ tick_keys_ff) & kar_pkg::EDGE_MASK) != '0) begin
         changed_in = 1'b1;
      end
      held_in = tick_keys_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_delay_ff <= kar_pkg::REPEAT_DELAY_RESET;
         first_pause_ff  <= kar_pkg::FIRST_PAUSE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            kar_pkg::CSR_REPEAT_DELAY: repeat_delay_ff <= csr_data;
            kar_pkg::CSR_FIRST_PAUSE:  first_pause_ff  <= csr_data;
         endcase
      end
   end

   // control state and key state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         held_ff       <= '0;
         for (int i = 0; i < kar_pkg::NREP; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance && tick_valid_ff) begin
            held_ff <= held_in;
            for (int i = 0; i < kar_pkg::NREP; i++) begin
               count_ff[i] <= count_in[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tick_keys_ff <= req_keys_now;
      end
      if (advance && tick_valid_ff) begin
         rsp_changed_ff <= changed_in;
         rsp_keys_ff    <= held_in;
      end
   end

endmodule

[sv/kar_checker.sv]
module kar_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_changed,
   input logic [kar_pkg::KEY_BITS-1:0]   rsp_keys_held
);

   kar_pkg::keys_type last_keys_ff;

   // held keys of the last delivered beat
   always_ff @(posedge clock) begin
      if (reset) begin
         last_keys_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_keys_ff <= rsp_keys_held;
      end
   end

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_changed)
                                 && $stable(rsp_keys_held))
      else $error("stalled result changed");

   // a newly held repeat key is a press
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_keys_held & ~last_keys_ff & kar_pkg::REP_MASK) != '0)
      |-> rsp_changed)
      else $error("press without change");

   // any edge key difference is a change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (((rsp_keys_held ^ last_keys_ff) & kar_pkg::EDGE_MASK) != '0)
      |-> rsp_changed)
      else $error("edge key change not reported");

endmodule

bind keypad_auto_repeat kar_checker u_kar_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_changed   (rsp_changed),
   .rsp_keys_held (rsp_keys_held)
);

[tb/keypad_auto_repeat_test.sv]
module keypad_auto_repeat_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PHASES     = 11;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // one report beat as the block should produce it
   typedef struct packed {
      logic              changed;
      kar_pkg::keys_type keys_held;
   } report_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   kar_pkg::keys_type                req_keys_now = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_changed;
   kar_pkg::keys_type                rsp_keys_held;
   logic                             csr_wr_en = 1'b0;
   kar_pkg::csr_index_type           csr_index = kar_pkg::CSR_REPEAT_DELAY;
   logic [kar_pkg::CSR_BITS-1:0]     csr_data = '0;

   // typematic state mirrored on the bench side
   kar_pkg::keys_type                held_now = '0;
   logic [kar_pkg::NREP-1:0]         timer_on = '0;
   kar_pkg::timer_type               timer_left [kar_pkg::NREP];
   kar_pkg::timer_type               delay_reg = kar_pkg::REPEAT_DELAY_RESET;
   kar_pkg::timer_type               pause_reg = kar_pkg::FIRST_PAUSE_RESET;

   kar_pkg::keys_type                tick_q [$];
   report_type                       report_q [$];

   int                               ticks_sent = 0;
   int                               ticks_accepted = 0;
   int                               reports_checked = 0;
   int                               changes_seen = 0;
   int                               fail_count = 0;
   int                               quiet_cycles = 0;
   int                               send_gap = 0;
   int                               stall_left = 0;
   bit                               send_calm = 1'b0;
   bit                               recv_calm = 1'b0;

   // opening ticks: field extremes, each key alone, edge keys both ways
   kar_pkg::keys_type                warmup_ticks [18] =
      '{6'd0, 6'd63, 6'd63, 6'd0, 6'd1, 6'd0, 6'd2, 6'd0, 6'd4, 6'd0, 6'd8, 6'd0,
        6'd16, 6'd0, 6'd32, 6'd0, 6'd63, 6'd0};
   // zero delays: every running timer should fire each tick
   kar_pkg::keys_type                zero_delay_ticks [7] =
      '{6'd15, 6'd15, 6'd15, 6'd15, 6'd0, 6'd48, 6'd48};

   // per phase register values, stimulus size and key hold limit (rare holds reach four times it)
   int unsigned                      phase_delay [NUM_PHASES] =
      '{100, 0, 1, 65535, 3, 0, 0, 65535, 1, 0, 2};
   int unsigned                      phase_pause [NUM_PHASES] =
      '{500, 0, 1, 65535, 7, 0, 0, 1, 65535, 0, 2};
   int                               phase_items [NUM_PHASES] =
      '{100, 100, 120, 100, 150, 150, 150, 100, 100, 100, 80};
   int                               phase_hold [NUM_PHASES] =
      '{40, 10, 10, 30, 30, 60, 60, 20, 20, 40, 12};

   keypad_auto_repeat u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_keys_now  (req_keys_now),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_changed   (rsp_changed),
      .rsp_keys_held (rsp_keys_held),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // one tick of the typematic logic, queues the report it yields
   task automatic advance_typematic(input kar_pkg::keys_type now);
      report_type r;
      r.changed = 1'b0;
      for (int i = 0; i < kar_pkg::NREP; i++) begin
         if (now[i] && !held_now[i]) begin
            // press: report and arm with the first pause
            held_now[i]   = 1'b1;
            timer_on[i]   = 1'b1;
            timer_left[i] = pause_reg;
            r.changed     = 1'b1;
         end else if (!now[i] && held_now[i]) begin
            // release: silent, timer stopped and cleared
            held_now[i]   = 1'b0;
            timer_on[i]   = 1'b0;
            timer_left[i] = '0;
         end else if (timer_on[i]) begin
            // zero counts like one, so an expired or zero timer fires now
            if (timer_left[i] <= 1) begin
               timer_left[i] = delay_reg;
               r.changed     = 1'b1;
            end else begin
               timer_left[i] = timer_left[i] - 1'b1;
            end
         end
      end
      if (((held_now ^ now) & kar_pkg::EDGE_MASK) != '0) r.changed = 1'b1;
      held_now = (held_now & kar_pkg::REP_MASK) | (now & kar_pkg::EDGE_MASK);
      r.keys_held = held_now;
      report_q.push_back(r);
   endtask

   // held key patterns with random flicker, plus short bursts of noise
   task automatic queue_random(input int n, input int hold_max);
      int                added;
      int                len;
      kar_pkg::keys_type pat;
      added = 0;
      while (added < n) begin
         if ($urandom_range(0, 99) < 80) begin
            pat = kar_pkg::keys_type'($urandom_range(0, 63));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4 * hold_max)
                                              : $urandom_range(1, hold_max);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0)
                  pat ^= kar_pkg::keys_type'(1 << $urandom_range(0, kar_pkg::KEY_BITS - 1));
               tick_q.push_back(pat);
            end
            added += len;
         end else begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               tick_q.push_back(kar_pkg::keys_type'($urandom_range(0, 63)));
            added += len;
         end
      end
   endtask

   // hold off until every beat sent has come back, then let the pipe drain
   task automatic settle();
      while (tick_q.size() != 0 || ticks_sent != reports_checked)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_keys_now <= '0;
      end else begin
         if (req_valid && req_ready) begin
            advance_typematic(req_keys_now);
            ticks_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
               req_valid    <= 1'b1;
               req_keys_now <= tick_q.pop_front();
               ticks_sent++;
               if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
               send_gap = pick_gap(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and backpressure
   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (report_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: unexpected beat changed=%0b keys_held=%02h",
                           $time, rsp_changed, rsp_keys_held);
            end else begin
               want = report_q.pop_front();
               reports_checked++;
               if (rsp_changed) changes_seen++;
               if (rsp_changed !== want.changed ||
                   rsp_keys_held !== want.keys_held) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display({"%0t: beat %0d mismatch: changed exp %0b got %0b, ",
                               "keys_held exp %02h got %02h"},
                              $time, reports_checked, want.changed, rsp_changed,
                              want.keys_held, rsp_keys_held);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
            stall_left = pick_gap(recv_calm);
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("keypad_auto_repeat regression: fail");
            $finish;
         end
      end
   end

   // phase sequencer
   initial begin
      for (int i = 0; i < kar_pkg::NREP; i++) timer_left[i] = '0;
      // a few phases with random register values
      phase_delay[5] = $urandom_range(1, 20);
      phase_pause[5] = $urandom_range(1, 40);
      phase_delay[6] = $urandom_range(1, 20);
      phase_pause[6] = $urandom_range(1, 40);
      phase_delay[9] = $urandom_range(1, 65535);
      phase_pause[9] = $urandom_range(1, 65535);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         // registers change only with the block idle; reset values hold first
         if (p != 0) begin
            @(posedge clock);
            csr_wr_en <= 1'b1;
            csr_index <= kar_pkg::CSR_REPEAT_DELAY;
            csr_data  <= kar_pkg::CSR_BITS'(phase_delay[p]);
            @(posedge clock);
            csr_index <= kar_pkg::CSR_FIRST_PAUSE;
            csr_data  <= kar_pkg::CSR_BITS'(phase_pause[p]);
            @(posedge clock);
            csr_wr_en <= 1'b0;
            delay_reg = kar_pkg::timer_type'(phase_delay[p]);
            pause_reg = kar_pkg::timer_type'(phase_pause[p]);
         end
         if (p == 0)
            foreach (warmup_ticks[k]) tick_q.push_back(warmup_ticks[k]);
         if (p == 1)
            foreach (zero_delay_ticks[k]) tick_q.push_back(zero_delay_ticks[k]);
         queue_random(phase_items[p], phase_hold[p]);
         settle();
      end

      if (report_q.size() != 0) begin
         fail_count += report_q.size();
         $display("%0d expected beats never arrived", report_q.size());
      end
      $display("covered %0d ticks over %0d delay settings, %0d reports checked",
               ticks_accepted, NUM_PHASES, reports_checked);
      $display("%0d reports flagged a change, %0d failures", changes_seen, fail_count);
      if (fail_count == 0) begin
         $display("keypad_auto_repeat regression: pass");
      end else begin
         $display("keypad_auto_repeat regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
sv/kar_pkg.sv
sv/keypad_auto_repeat.sv
sv/kar_checker.sv
tb/keypad_auto_repeat_test.sv
